/* src/tsp_pkg.sv */
// types, constants and register indexes shared by the slot planner files
`timescale 1ns / 1ps

package tsp_pkg;

    // largest group size; rank fields are 6 bits wide, counts 7 bits
    localparam int MAX_RANKS = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_RANK_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_BYTES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_BYTES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_BYTES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCRATCH_BASE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_STRIDE = 3'd5;

    typedef struct packed {
        logic [6:0]  rank_count;
        logic [3:0]  elem_bytes;
        logic [31:0] slice_bytes;
        logic [31:0] tail_bytes;
        logic [47:0] scratch_base;
        logic [31:0] repeat_stride;
    } t_cfg;

    typedef struct packed {
        logic [5:0]  owner_rank;
        logic [5:0]  source_rank;
        logic [15:0] repeat_index;
        logic        second_shot;
    } t_in_item;

    typedef struct packed {
        logic        is_unpaired;
        logic        is_second_remote;
        logic [5:0]  group_slot;
        logic [5:0]  paired_source;
        logic [31:0] shot_offset;
        logic [31:0] shot_size;
        logic [31:0] dest_offset;
        logic [47:0] slot_address;
        logic        reduce_in_post;
        logic        two_shot_ok;
    } t_out_item;

    // half-slice sizes derived from the configuration
    typedef struct packed {
        logic        busy;
        logic [31:0] half_a;
        logic [31:0] half_b;
        logic [31:0] size_b;
        logic        halves_ok;
    } t_half_info;

    // rank results leaving the rank pipeline
    typedef struct packed {
        logic [5:0]  owner;
        logic [5:0]  source;
        logic        unp;
        logic        sec;
        logic [6:0]  partner_ord;
        logic [7:0]  partner_sum;
        logic [7:0]  group_sum;
        logic        is_last;
        logic [15:0] repeat_index;
        logic        second_shot;
    } t_rank_info;

endpackage

/* src/tsp_if.sv */
// valid/ready channel interfaces for planner queries and results
`timescale 1ns / 1ps

interface tsp_in_if;
    import tsp_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tsp_out_if;
    import tsp_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/two_shot_scatter_slot_planner.sv */
// two-shot reduce-scatter slot planner: config registers and output stages
// a query passes the rank pipeline and stages 5 and 6 before the output register
// throughput: one query per cycle while the output is ready and the divider is idle
// after each configuration write the input is held off while the half-slice
// divider runs, one quotient bit per cycle for both slice sizes
// reset: synchronous, registers to their defaults, pipeline empty, no clearing pass
`timescale 1ns / 1ps

module two_shot_scatter_slot_planner (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tsp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tsp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    tsp_in_if.sink                           i_req,
    tsp_out_if.source                        o_rsp
);
    import tsp_pkg::*;

    t_cfg       r_cfg;
    t_half_info w_half;
    t_rank_info w_rinfo;
    logic       w_rvalid;
    logic       w_rp_ready;
    logic [6:0] w_ranks;

    // stage 5
    logic        r_s5_valid;
    logic [5:0]  r_s5_slot;
    logic [5:0]  r_s5_partner;
    logic        r_s5_unp;
    logic        r_s5_sec;
    logic        r_s5_off_sel;
    logic        r_s5_dst_sel;
    logic [31:0] r_s5_sz;
    logic [31:0] r_s5_half;
    logic        r_s5_ok;
    logic [15:0] r_s5_rep;
    // stage 6
    logic        r_s6_valid;
    logic [5:0]  r_s6_slot;
    logic [5:0]  r_s6_partner;
    logic        r_s6_unp;
    logic        r_s6_sec;
    logic [31:0] r_s6_off;
    logic [31:0] r_s6_size;
    logic [31:0] r_s6_dst;
    logic [47:0] r_s6_rep_prod;
    logic [37:0] r_s6_slot_prod;
    logic        r_s6_ok;
    // stage 7, the output register
    logic        r_s7_valid;
    t_out_item   r_s7_out;

    logic        w_rdy5, w_rdy6, w_rdy7;
    logic [5:0]  n_s5_pp;
    logic [5:0]  w_u;
    logic        w_u_big;
    logic        n_s5_unp_p;
    logic        n_s5_sec_p;
    logic        n_s5_off_sel;
    logic [31:0] n_s6_off;

    // x mod r for x up to 2r
    function automatic logic [5:0] f_mod2(logic [7:0] x, logic [6:0] r);
        logic [7:0] t;
        t = x;
        if (t >= {r, 1'b0}) begin
            t = t - {r, 1'b0};
        end else if (t >= {1'b0, r}) begin
            t = t - {1'b0, r};
        end
        return t[5:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rank_count    <= 7'd8;
            r_cfg.elem_bytes    <= 4'd4;
            r_cfg.slice_bytes   <= '0;
            r_cfg.tail_bytes    <= '0;
            r_cfg.scratch_base  <= '0;
            r_cfg.repeat_stride <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RANK_COUNT:    r_cfg.rank_count    <= 7'(i_cfg_data);
                CFG_ELEM_BYTES:    r_cfg.elem_bytes    <= 4'(i_cfg_data);
                CFG_SLICE_BYTES:   r_cfg.slice_bytes   <= 32'(i_cfg_data);
                CFG_TAIL_BYTES:    r_cfg.tail_bytes    <= 32'(i_cfg_data);
                CFG_SCRATCH_BASE:  r_cfg.scratch_base  <= i_cfg_data[47:0];
                CFG_REPEAT_STRIDE: r_cfg.repeat_stride <= 32'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // effective rank count: zero acts as one, large counts saturate
    assign w_ranks = (r_cfg.rank_count == 7'd0) ? 7'd1 :
                     (r_cfg.rank_count > 7'(MAX_RANKS)) ? 7'(MAX_RANKS) : r_cfg.rank_count;

    tsp_half_unit u_half (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg   (r_cfg),
        .o_half  (w_half)
    );

    tsp_rank_pipe u_rank (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ranks(w_ranks),
        .i_valid(i_req.valid && !w_half.busy),
        .i_item (i_req.data),
        .o_ready(w_rp_ready),
        .o_valid(w_rvalid),
        .o_info (w_rinfo),
        .i_ready(w_rdy5)
    );

    assign i_req.ready = w_rp_ready && !w_half.busy;

    assign w_rdy7 = !r_s7_valid || o_rsp.ready;
    assign w_rdy6 = !r_s6_valid || w_rdy7;
    assign w_rdy5 = !r_s5_valid || w_rdy6;

    assign w_u     = w_ranks[6:1] - 6'd1;
    assign w_u_big = (w_ranks < 7'd2);

    // partner's remote order is its pair position taken mod r
    always_comb begin
        n_s5_pp = (w_rinfo.partner_ord == w_ranks) ? 6'd0 : 6'(w_rinfo.partner_ord);
        n_s5_unp_p = !w_u_big && (n_s5_pp == w_u);
        n_s5_sec_p = (!w_u_big && (n_s5_pp > w_u)) ? !n_s5_pp[0] : n_s5_pp[0];
        n_s5_off_sel = w_rinfo.unp ? w_rinfo.second_shot
                                   : (w_rinfo.sec != w_rinfo.second_shot);
    end

    assign n_s6_off = r_s5_off_sel ? r_s5_half : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
        end else begin
            if (w_rdy5) begin
                r_s5_valid <= w_rvalid;
            end
            if (w_rdy6) begin
                r_s6_valid <= r_s5_valid;
            end
            if (w_rdy7) begin
                r_s7_valid <= r_s6_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && w_rvalid) begin
            r_s5_partner <= f_mod2(w_rinfo.partner_sum, w_ranks);
            r_s5_slot    <= w_rinfo.unp ? w_rinfo.source : f_mod2(w_rinfo.group_sum, w_ranks);
            r_s5_unp     <= w_rinfo.unp;
            r_s5_sec     <= w_rinfo.sec;
            r_s5_off_sel <= n_s5_off_sel;
            // paired second shot lands where the partner's first shot lands
            r_s5_dst_sel <= (w_rinfo.second_shot && !w_rinfo.unp) ?
                            (!n_s5_unp_p && n_s5_sec_p) : n_s5_off_sel;
            r_s5_sz      <= w_rinfo.is_last ? w_half.size_b : r_cfg.slice_bytes;
            r_s5_half    <= w_rinfo.is_last ? w_half.half_b : w_half.half_a;
            r_s5_ok      <= (w_ranks > 7'd2) && !w_ranks[0] && w_half.halves_ok;
            r_s5_rep     <= w_rinfo.repeat_index;
        end
        if (w_rdy6 && r_s5_valid) begin
            r_s6_slot      <= r_s5_slot;
            r_s6_partner   <= r_s5_partner;
            r_s6_unp       <= r_s5_unp;
            r_s6_sec       <= r_s5_sec;
            r_s6_off       <= n_s6_off;
            r_s6_size      <= (n_s6_off == 32'd0) ? r_s5_half : (r_s5_sz - r_s5_half);
            r_s6_dst       <= r_s5_dst_sel ? r_s5_half : 32'd0;
            r_s6_rep_prod  <= 48'(r_s5_rep) * 48'(r_cfg.repeat_stride);
            r_s6_slot_prod <= 38'(r_s5_slot) * 38'(r_cfg.slice_bytes);
            r_s6_ok        <= r_s5_ok;
        end
        if (w_rdy7 && r_s6_valid) begin
            r_s7_out.is_unpaired      <= r_s6_unp;
            r_s7_out.is_second_remote <= r_s6_sec;
            r_s7_out.group_slot       <= r_s6_slot;
            r_s7_out.paired_source    <= r_s6_partner;
            r_s7_out.shot_offset      <= r_s6_off;
            r_s7_out.shot_size        <= r_s6_size;
            r_s7_out.dest_offset      <= r_s6_dst;
            r_s7_out.slot_address     <= r_cfg.scratch_base + r_s6_rep_prod +
                                         48'(r_s6_slot_prod);
            r_s7_out.reduce_in_post   <= r_s6_unp || !r_s6_sec;
            r_s7_out.two_shot_ok      <= r_s6_ok;
        end
    end

    assign o_rsp.valid = r_s7_valid;
    assign o_rsp.data  = r_s7_out;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_half.busy |-> !i_req.ready)
        else $error("query accepted while half sizes are recomputed");

    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.two_shot_ok |-> o_rsp.data.shot_size != 32'd0)
        else $error("two-shot result with empty shot");

endmodule

/* src/tsp_half_unit.sv */
// bit-serial divider deriving the half-slice sizes after a configuration write
`timescale 1ns / 1ps

module tsp_half_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  tsp_pkg::t_cfg       i_cfg,
    output tsp_pkg::t_half_info o_half
);
    import tsp_pkg::*;

    localparam int DIV_STEPS = 32;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    typedef enum logic [3:0] {
        H_IDLE = 4'b0001,
        H_LOAD = 4'b0010,
        H_DIV  = 4'b0100,
        H_MUL  = 4'b1000
    } t_hstate;

    t_hstate           r_state;
    logic [STEP_W-1:0] r_cnt;
    logic [31:0]       r_xa;
    logic [31:0]       r_xb;
    logic [4:0]        r_ra;
    logic [4:0]        r_rb;
    logic [31:0]       r_half_a;
    logic [31:0]       r_half_b;

    logic [4:0]  w_div;
    logic [3:0]  w_mul;
    logic [31:0] w_size_b;
    logic [36:0] n_step_a;
    logic [36:0] n_step_b;

    // one restoring step: returns {remainder, shifted dividend with quotient bit}
    function automatic logic [36:0] f_div_step(logic [31:0] x, logic [4:0] rem,
                                               logic [4:0] d);
        logic [5:0] t;
        logic       q;
        t = {rem, x[31]};
        q = (t >= {1'b0, d});
        if (q) begin
            t = t - {1'b0, d};
        end
        return {t[4:0], x[30:0], q};
    endfunction

    // half = floor(size / (2 * elem)) * elem, elem of zero halves bytes
    assign w_div    = (i_cfg.elem_bytes == 4'd0) ? 5'd2 : {i_cfg.elem_bytes, 1'b0};
    assign w_mul    = (i_cfg.elem_bytes == 4'd0) ? 4'd1 : i_cfg.elem_bytes;
    assign w_size_b = (i_cfg.tail_bytes != 32'd0) ? i_cfg.tail_bytes : i_cfg.slice_bytes;

    assign n_step_a = f_div_step(r_xa, r_ra, w_div);
    assign n_step_b = f_div_step(r_xb, r_rb, w_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= H_IDLE;
            r_cnt    <= '0;
            r_half_a <= '0;
            r_half_b <= '0;
        end else if (i_cfg_we) begin
            r_state <= H_LOAD;
        end else begin
            unique case (r_state)
                H_IDLE: begin
                    r_state <= H_IDLE;
                end
                H_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= H_DIV;
                end
                H_DIV: begin
                    r_cnt <= r_cnt + STEP_W'(1);
                    if (r_cnt == STEP_LAST) begin
                        r_state <= H_MUL;
                    end
                end
                H_MUL: begin
                    r_half_a <= 32'(r_xa * 32'(w_mul));
                    r_half_b <= 32'(r_xb * 32'(w_mul));
                    r_state  <= H_IDLE;
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == H_LOAD) begin
            r_xa <= i_cfg.slice_bytes;
            r_xb <= w_size_b;
            r_ra <= '0;
            r_rb <= '0;
        end else if (r_state == H_DIV) begin
            r_xa <= n_step_a[31:0];
            r_ra <= n_step_a[36:32];
            r_xb <= n_step_b[31:0];
            r_rb <= n_step_b[36:32];
        end
    end

    assign o_half.busy      = (r_state != H_IDLE);
    assign o_half.half_a    = r_half_a;
    assign o_half.half_b    = r_half_b;
    assign o_half.size_b    = w_size_b;
    assign o_half.halves_ok = (r_state == H_IDLE) &&
                              (r_half_a != 32'd0) && (r_half_a != i_cfg.slice_bytes) &&
                              (r_half_b != 32'd0) && (r_half_b != w_size_b);

    a_busy_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_half.busy)
        else $error("half unit not busy after configuration write");

endmodule

/* src/tsp_rank_pipe.sv */
// four-stage rank pipeline: rank modulo, remote order, pair order and group sums
`timescale 1ns / 1ps

module tsp_rank_pipe (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [6:0]          i_ranks,
    input  logic                i_valid,
    input  tsp_pkg::t_in_item   i_item,
    output logic                o_ready,
    output logic                o_valid,
    output tsp_pkg::t_rank_info o_info,
    input  logic                i_ready
);
    import tsp_pkg::*;

    // stage 1: upper three remainder steps
    logic        r_s1_valid;
    logic [5:0]  r_s1_orem;
    logic [5:0]  r_s1_srem;
    logic [2:0]  r_s1_olo;
    logic [2:0]  r_s1_slo;
    logic [15:0] r_s1_rep;
    logic        r_s1_second;
    // stage 2: reduced ranks
    logic        r_s2_valid;
    logic [5:0]  r_s2_o;
    logic [5:0]  r_s2_s;
    logic [15:0] r_s2_rep;
    logic        r_s2_second;
    // stage 3: remote order
    logic        r_s3_valid;
    logic [5:0]  r_s3_o;
    logic [5:0]  r_s3_s;
    logic [5:0]  r_s3_ord;
    logic        r_s3_last;
    logic [15:0] r_s3_rep;
    logic        r_s3_second;
    // stage 4: pair results
    logic        r_s4_valid;
    t_rank_info  r_s4_info;

    logic       w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic [5:0] n_s1_orem, n_s1_srem, n_s2_o, n_s2_s, n_s3_ord, n_s4_pord;
    logic [7:0] n_s3_t;
    logic [5:0] w_u;
    logic       w_u_big;
    logic [6:0] n_s4_p, n_s4_g;

    function automatic logic [5:0] f_mod_step(logic [5:0] rem, logic b, logic [6:0] r);
        logic [6:0] t;
        t = {rem, b};
        if (t >= r) begin
            t = t - r;
        end
        return t[5:0];
    endfunction

    assign w_rdy4  = !r_s4_valid || i_ready;
    assign w_rdy3  = !r_s3_valid || w_rdy4;
    assign w_rdy2  = !r_s2_valid || w_rdy3;
    assign w_rdy1  = !r_s1_valid || w_rdy2;
    assign o_ready = w_rdy1;

    // unpaired order position r/2-1; wraps past every order for a single rank
    assign w_u     = i_ranks[6:1] - 6'd1;
    assign w_u_big = (i_ranks < 7'd2);

    always_comb begin
        n_s1_orem = '0;
        n_s1_srem = '0;
        for (int i = 5; i >= 3; i--) begin
            n_s1_orem = f_mod_step(n_s1_orem, i_item.owner_rank[i], i_ranks);
            n_s1_srem = f_mod_step(n_s1_srem, i_item.source_rank[i], i_ranks);
        end
    end

    always_comb begin
        n_s2_o = r_s1_orem;
        n_s2_s = r_s1_srem;
        for (int i = 2; i >= 0; i--) begin
            n_s2_o = f_mod_step(n_s2_o, r_s1_olo[i], i_ranks);
            n_s2_s = f_mod_step(n_s2_s, r_s1_slo[i], i_ranks);
        end
    end

    // order = (s + r - o - 1) mod r, sum stays below 2r
    assign n_s3_t   = 8'(r_s2_s) + 8'(i_ranks) - 8'(r_s2_o) - 8'd1;
    assign n_s3_ord = (n_s3_t >= 8'(i_ranks)) ? 6'(n_s3_t - 8'(i_ranks)) : 6'(n_s3_t);

    always_comb begin
        n_s4_pord = r_s3_ord;
        if (!w_u_big && (r_s3_ord > w_u)) begin
            n_s4_pord = r_s3_ord - 6'd1;
        end
        n_s4_p = {1'b0, n_s4_pord ^ 6'd1};
        n_s4_g = {1'b0, n_s4_pord[5:1], 1'b0};
        // skip over the unpaired position
        if (!w_u_big && (n_s4_p >= {1'b0, w_u})) begin
            n_s4_p = n_s4_p + 7'd1;
        end
        if (!w_u_big && (n_s4_g >= {1'b0, w_u})) begin
            n_s4_g = n_s4_g + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_s1_valid <= i_valid;
            end
            if (w_rdy2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_rdy3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_rdy4) begin
                r_s4_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_s1_orem   <= n_s1_orem;
            r_s1_srem   <= n_s1_srem;
            r_s1_olo    <= i_item.owner_rank[2:0];
            r_s1_slo    <= i_item.source_rank[2:0];
            r_s1_rep    <= i_item.repeat_index;
            r_s1_second <= i_item.second_shot;
        end
        if (w_rdy2 && r_s1_valid) begin
            r_s2_o      <= n_s2_o;
            r_s2_s      <= n_s2_s;
            r_s2_rep    <= r_s1_rep;
            r_s2_second <= r_s1_second;
        end
        if (w_rdy3 && r_s2_valid) begin
            r_s3_o      <= r_s2_o;
            r_s3_s      <= r_s2_s;
            r_s3_ord    <= n_s3_ord;
            r_s3_last   <= ({1'b0, r_s2_o} == (i_ranks - 7'd1));
            r_s3_rep    <= r_s2_rep;
            r_s3_second <= r_s2_second;
        end
        if (w_rdy4 && r_s3_valid) begin
            r_s4_info.owner        <= r_s3_o;
            r_s4_info.source       <= r_s3_s;
            r_s4_info.unp          <= !w_u_big && (r_s3_ord == w_u);
            r_s4_info.sec          <= n_s4_pord[0];
            r_s4_info.partner_ord  <= n_s4_p;
            r_s4_info.partner_sum  <= 8'(r_s3_o) + 8'd1 + {1'b0, n_s4_p};
            r_s4_info.group_sum    <= 8'(r_s3_o) + 8'd1 + {1'b0, n_s4_g};
            r_s4_info.is_last      <= r_s3_last;
            r_s4_info.repeat_index <= r_s3_rep;
            r_s4_info.second_shot  <= r_s3_second;
        end
    end

    assign o_valid = r_s4_valid;
    assign o_info  = r_s4_info;

    a_s4_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid && !i_ready |=> r_s4_valid)
        else $error("stalled rank transaction dropped");

endmodule
